### design/rplc_pkg.sv
package rplc_pkg;

  // Control message codes.
  localparam logic [7:0] CODE_DIO = 8'd1;
  localparam logic [7:0] CODE_DAO = 8'd2;

  // Option type codes.
  localparam logic [7:0] TYPE_PAD1    = 8'd0;
  localparam logic [7:0] TYPE_CONF    = 8'd4;
  localparam logic [7:0] TYPE_TARGET  = 8'd5;
  localparam logic [7:0] TYPE_TRANSIT = 8'd6;
  localparam logic [7:0] TYPE_PREFIX  = 8'd8;

  // Option body lengths.
  localparam logic [7:0] LEN_CONF        = 8'd14;
  localparam logic [7:0] LEN_TARGET_MAX  = 8'd18;
  localparam logic [7:0] LEN_TRANSIT     = 8'd4;
  localparam logic [7:0] LEN_PARENT_ADDR = 8'd16;
  localparam logic [7:0] LEN_PREFIX      = 8'd30;

  // Verdict codes.
  localparam logic [1:0] VERDICT_OK          = 2'd0;
  localparam logic [1:0] VERDICT_NOT_ALLOWED = 2'd1;
  localparam logic [1:0] VERDICT_BAD_LEN     = 2'd2;
  localparam logic [1:0] VERDICT_TOTAL       = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] msg_code;
    logic       last_byte;
    logic       empty_area;
  } in_item_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic       is_valid;
  } out_item_t;

endpackage

### design/rplc_in_stage.sv
module rplc_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rplc_pkg::in_item_t in_i,
  input  logic               space_i,
  output logic               item_valid_o,
  output rplc_pkg::in_item_t item_o
);

  logic               valid_q, valid_d;
  rplc_pkg::in_item_t item_q;

  // The held byte leaves whenever the result side has room, so a new
  // transaction can be taken in the same cycle.
  assign in_ready_o = !valid_q || space_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

### design/rplc_parser.sv
module rplc_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                step_i,
  input  rplc_pkg::in_item_t  item_i,
  output logic                res_valid_o,
  output rplc_pkg::out_item_t res_o
);

  localparam logic [1:0] PH_TYPE = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  localparam logic [7:0] LEN_TRANSIT_SUM = rplc_pkg::LEN_TRANSIT + rplc_pkg::LEN_PARENT_ADDR;

  logic       nonstoring_mode_q;
  logic [1:0] phase_q, phase_d;
  logic [7:0] left_q, left_d;
  logic [7:0] type_q, type_d;
  logic [1:0] err_q, err_d;

  logic [1:0] opt_err;
  logic [1:0] err_next;
  logic [7:0] transit_len;
  logic [7:0] left_dec;
  logic       ends_clean;
  logic [1:0] verdict;

  assign transit_len = nonstoring_mode_q ? (LEN_TRANSIT_SUM) : rplc_pkg::LEN_TRANSIT;

  // Option rule check, applied when the length byte arrives.
  always_comb begin
    opt_err = rplc_pkg::VERDICT_OK;
    case (type_q)
      rplc_pkg::TYPE_CONF: begin
        if (item_i.msg_code != rplc_pkg::CODE_DIO) begin
          opt_err = rplc_pkg::VERDICT_NOT_ALLOWED;
        end else if (item_i.data_byte != rplc_pkg::LEN_CONF) begin
          opt_err = rplc_pkg::VERDICT_BAD_LEN;
        end
      end
      rplc_pkg::TYPE_PREFIX: begin
        if (item_i.msg_code != rplc_pkg::CODE_DIO) begin
          opt_err = rplc_pkg::VERDICT_NOT_ALLOWED;
        end else if (item_i.data_byte != rplc_pkg::LEN_PREFIX) begin
          opt_err = rplc_pkg::VERDICT_BAD_LEN;
        end
      end
      rplc_pkg::TYPE_TARGET: begin
        if (item_i.msg_code != rplc_pkg::CODE_DAO) begin
          opt_err = rplc_pkg::VERDICT_NOT_ALLOWED;
        end else if (item_i.data_byte > rplc_pkg::LEN_TARGET_MAX) begin
          opt_err = rplc_pkg::VERDICT_BAD_LEN;
        end
      end
      rplc_pkg::TYPE_TRANSIT: begin
        if (item_i.msg_code != rplc_pkg::CODE_DAO) begin
          opt_err = rplc_pkg::VERDICT_NOT_ALLOWED;
        end else if (item_i.data_byte != transit_len) begin
          opt_err = rplc_pkg::VERDICT_BAD_LEN;
        end
      end
      default: begin
        opt_err = rplc_pkg::VERDICT_OK;
      end
    endcase
  end

  assign left_dec = (left_q != 8'd0) ? (left_q - 8'd1) : 8'd0;

  always_comb begin
    phase_d     = phase_q;
    left_d      = left_q;
    type_d      = type_q;
    err_next    = err_q;
    ends_clean  = 1'b0;
    verdict     = rplc_pkg::VERDICT_OK;
    res_valid_o = 1'b0;

    unique case (phase_q)
      PH_LEN: begin
        if (err_q == rplc_pkg::VERDICT_OK) begin
          err_next = opt_err;
        end
        ends_clean = (item_i.data_byte == 8'd0);
        left_d     = item_i.data_byte;
        phase_d    = (item_i.data_byte == 8'd0) ? PH_TYPE : PH_BODY;
      end
      PH_BODY: begin
        ends_clean = (left_q == 8'd1);
        left_d     = left_dec;
        if (left_dec == 8'd0) begin
          phase_d = PH_TYPE;
        end
      end
      default: begin
        // The unused phase code parses as a type byte.
        if (item_i.data_byte == rplc_pkg::TYPE_PAD1) begin
          ends_clean = 1'b1;
          phase_d    = PH_TYPE;
        end else begin
          type_d  = item_i.data_byte;
          phase_d = PH_LEN;
        end
      end
    endcase

    err_d = err_next;
    if (err_next != rplc_pkg::VERDICT_OK) begin
      verdict = err_next;
    end else if (!ends_clean) begin
      verdict = rplc_pkg::VERDICT_TOTAL;
    end

    if (item_i.empty_area) begin
      verdict = rplc_pkg::VERDICT_OK;
    end

    // Any verdict ends the message and returns the parser to its start.
    if (item_i.empty_area || item_i.last_byte) begin
      res_valid_o = step_i;
      phase_d     = PH_TYPE;
      left_d      = 8'd0;
      type_d      = 8'd0;
      err_d       = rplc_pkg::VERDICT_OK;
    end
  end

  assign res_o.verdict  = verdict;
  assign res_o.is_valid = (verdict == rplc_pkg::VERDICT_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonstoring_mode_q <= 1'b0;
      phase_q           <= PH_TYPE;
      left_q            <= 8'd0;
      type_q            <= 8'd0;
      err_q             <= rplc_pkg::VERDICT_OK;
    end else begin
      if (cfg_we_i) begin
        nonstoring_mode_q <= cfg_wdata_i;
      end
      if (step_i) begin
        phase_q <= phase_d;
        left_q  <= left_d;
        type_q  <= type_d;
        err_q   <= err_d;
      end
    end
  end

endmodule

### design/rplc_out_stage.sv
module rplc_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                res_valid_i,
  input  rplc_pkg::out_item_t res_i,
  output logic                space_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rplc_pkg::out_item_t out_o
);

  logic                valid_q, valid_d;
  rplc_pkg::out_item_t res_q;

  assign space_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_valid_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

endmodule

### design/rpl_option_tlv_checker.sv
// Option checker for routing control messages. The option area arrives one
// byte per input transaction, tagged with its message code and a last-byte
// mark (or a single transaction with empty_area set for a message without
// options); one verdict transaction comes out per message. The block takes
// one byte every clock cycle while verdicts are taken: each byte is held in
// an input register, and once the result side has room a small parse-and-check
// step updates the option walker and, on the final byte, writes the verdict
// into the result register. The result register frees the input side while a
// verdict waits; a verdict that is not taken stalls the input once the next
// byte sits in the input register. The user must see that nonstoring_mode is
// written through cfg_we_i while no message is in flight; no logic checks it.
module rpl_option_tlv_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rplc_pkg::in_item_t  in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rplc_pkg::out_item_t out_o
);

  logic                space;
  logic                item_valid;
  rplc_pkg::in_item_t  item;
  logic                step;
  logic                res_valid;
  rplc_pkg::out_item_t res;

  rplc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_i         (in_i),
    .space_i      (space),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  assign step = item_valid && space;

  rplc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  rplc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  // The flag and the code of a verdict must agree.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.is_valid == (out_o.verdict == rplc_pkg::VERDICT_OK)))
    else $error("is_valid disagrees with verdict");

  // The input side only stalls behind a verdict that is not being taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a blocked verdict");

  // A new verdict always comes from a byte that left the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(step))
    else $error("verdict appeared without a parsed transaction");

endmodule
